// ===== hw/rtl/ipv4_receive_header_check_defines.svh =====
// assertion macros for the ipv4 receive header check
// used by the top level only; no other dependencies
`ifndef IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH
`ifndef SYNTHESIS
`define IPV4RHC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ipv4rhc assertion failed");
`define IPV4RHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ipv4rhc assertion failed");
`else
`define IPV4RHC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define IPV4RHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/ipv4rhc_pkg.sv =====
// shared types and constants for the ipv4 receive header check
// no dependencies
package ipv4rhc_pkg;

	typedef enum logic [2:0] {
		VerdictDeliver    = 3'd0,
		VerdictShort      = 3'd1,
		VerdictBadHeader  = 3'd2,
		VerdictBadCsum    = 3'd3,
		VerdictNotForUs   = 3'd4,
		VerdictProtoUnrch = 3'd5
	} verdict_t;

	localparam logic [3:0]  IpVersion4    = 4'd4;
	localparam logic [3:0]  MinHdrWords   = 4'd5;
	localparam logic [15:0] MinFrameBytes = 16'd20;
	localparam logic [7:0]  ProtoIcmp     = 8'd1;
	localparam logic [7:0]  ProtoUdp      = 8'd17;

	// header byte positions
	localparam logic [15:0] PosVerIhl   = 16'd0;
	localparam logic [15:0] PosLenHi    = 16'd2;
	localparam logic [15:0] PosLenLo    = 16'd3;
	localparam logic [15:0] PosProto    = 16'd9;
	localparam logic [15:0] PosCsumHi   = 16'd10;
	localparam logic [15:0] PosCsumLo   = 16'd11;
	localparam logic [15:0] PosSrcFirst = 16'd12;
	localparam logic [15:0] PosDstFirst = 16'd16;
	localparam logic [15:0] PosDstEnd   = 16'd20;
	localparam logic [15:0] CountMax    = 16'hFFFF;

	// frame state after the current byte has been folded in
	typedef struct packed {
		logic [15:0] byte_count;
		logic [3:0]  version;
		logic [3:0]  ihl;
		logic [15:0] total_len;
		logic [7:0]  protocol;
		logic [31:0] source;
		logic [31:0] dest;
		logic [15:0] stored_csum;
		logic [15:0] sum;
	} frame_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  protocol;
		logic [31:0] source_ip;
		logic [5:0]  header_bytes;
		logic [15:0] payload_len;
		logic [15:0] pad_bytes;
	} result_t;

endpackage

// ===== hw/rtl/ipv4rhc_frame_acc.sv =====
// per-frame header capture and ones' complement sum accumulation
// depends on ipv4rhc_pkg
module ipv4rhc_frame_acc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output ipv4rhc_pkg::frame_t frame
);
	import ipv4rhc_pkg::*;

	logic [15:0] count_q;
	logic [3:0]  version_q;
	logic [3:0]  ihl_q;
	logic [15:0] total_len_q;
	logic [7:0]  protocol_q;
	logic [31:0] source_q;
	logic [31:0] dest_q;
	logic [15:0] csum_q;
	logic [15:0] sum_q;
	logic [7:0]  hold_q;

	logic [7:0]  hold_n;
	logic [15:0] word;
	logic [16:0] sum_wide;
	logic [5:0]  hdr_bytes;
	frame_t      nxt;

	always_comb begin
		nxt.byte_count  = (count_q != CountMax) ? count_q + 16'd1 : count_q;
		nxt.version     = version_q;
		nxt.ihl         = ihl_q;
		nxt.total_len   = total_len_q;
		nxt.protocol    = protocol_q;
		nxt.source      = source_q;
		nxt.dest        = dest_q;
		nxt.stored_csum = csum_q;
		nxt.sum         = sum_q;
		hold_n          = hold_q;
		word            = 16'd0;
		sum_wide        = 17'd0;

		case (count_q)
			PosVerIhl: begin
				nxt.version = data_byte[7:4];
				nxt.ihl     = data_byte[3:0];
			end
			PosLenHi:  nxt.total_len[15:8]   = data_byte;
			PosLenLo:  nxt.total_len[7:0]    = data_byte;
			PosProto:  nxt.protocol          = data_byte;
			PosCsumHi: nxt.stored_csum[15:8] = data_byte;
			PosCsumLo: nxt.stored_csum[7:0]  = data_byte;
			default: ;
		endcase

		if (count_q >= PosSrcFirst && count_q < PosDstFirst) begin
			nxt.source = {source_q[23:0], data_byte};
		end else if (count_q >= PosDstFirst && count_q < PosDstEnd) begin
			nxt.dest = {dest_q[23:0], data_byte};
		end

		// sum covers the header only, checksum field counted as zero
		hdr_bytes = {nxt.ihl, 2'b00};
		if (count_q < {10'd0, hdr_bytes}) begin
			if (!count_q[0]) begin
				hold_n = data_byte;
			end else begin
				word     = (count_q == PosCsumLo) ? 16'd0 : {hold_q, data_byte};
				sum_wide = {1'b0, sum_q} + {1'b0, word};
				// end-around carry
				nxt.sum  = sum_wide[16] ? sum_wide[15:0] + 16'd1 : sum_wide[15:0];
			end
		end
	end

	assign frame = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			version_q   <= '0;
			ihl_q       <= '0;
			total_len_q <= '0;
			protocol_q  <= '0;
			source_q    <= '0;
			dest_q      <= '0;
			csum_q      <= '0;
			sum_q       <= '0;
			hold_q      <= '0;
		end else if (go) begin
			if (last_byte) begin
				count_q     <= '0;
				version_q   <= '0;
				ihl_q       <= '0;
				total_len_q <= '0;
				protocol_q  <= '0;
				source_q    <= '0;
				dest_q      <= '0;
				csum_q      <= '0;
				sum_q       <= '0;
				hold_q      <= '0;
			end else begin
				count_q     <= nxt.byte_count;
				version_q   <= nxt.version;
				ihl_q       <= nxt.ihl;
				total_len_q <= nxt.total_len;
				protocol_q  <= nxt.protocol;
				source_q    <= nxt.source;
				dest_q      <= nxt.dest;
				csum_q      <= nxt.stored_csum;
				sum_q       <= nxt.sum;
				hold_q      <= hold_n;
			end
		end
	end

endmodule

// ===== hw/rtl/ipv4rhc_verdict.sv =====
// end-of-frame checks and result field derivation
// depends on ipv4rhc_pkg
module ipv4rhc_verdict (
	input  ipv4rhc_pkg::frame_t  frame,
	input  logic [31:0]          local_ip,
	output ipv4rhc_pkg::result_t result
);
	import ipv4rhc_pkg::*;

	logic [5:0]  hdr_bytes;
	logic [15:0] hdr_bytes_w;
	logic [15:0] flen;
	logic [15:0] computed;
	logic        bad_header;

	always_comb begin
		flen        = frame.byte_count;
		hdr_bytes   = {frame.ihl, 2'b00};
		hdr_bytes_w = {10'd0, hdr_bytes};
		computed    = ~frame.sum;
		bad_header  = (frame.version != IpVersion4) || (frame.total_len > flen)
			|| (frame.ihl < MinHdrWords);

		// first failing check wins
		if (flen < MinFrameBytes) begin
			result.verdict = VerdictShort;
		end else if (bad_header) begin
			result.verdict = VerdictBadHeader;
		end else if (flen < hdr_bytes_w) begin
			result.verdict = VerdictShort;
		end else if (computed != frame.stored_csum) begin
			result.verdict = VerdictBadCsum;
		end else if (frame.dest != local_ip) begin
			result.verdict = VerdictNotForUs;
		end else if (frame.protocol != ProtoIcmp && frame.protocol != ProtoUdp) begin
			result.verdict = VerdictProtoUnrch;
		end else begin
			result.verdict = VerdictDeliver;
		end

		result.protocol     = frame.protocol;
		result.source_ip    = frame.source;
		result.header_bytes = hdr_bytes;
		result.payload_len  = (frame.total_len > hdr_bytes_w) ?
			frame.total_len - hdr_bytes_w : 16'd0;
		result.pad_bytes    = (flen > frame.total_len) ? flen - frame.total_len : 16'd0;
	end

endmodule

// ===== hw/rtl/ipv4_receive_header_check.sv =====
// top level of the ipv4 receive header check: input register, frame state, result register
// depends on ipv4rhc_pkg, ipv4rhc_frame_acc, ipv4rhc_verdict and the defines header
//
// usage:
//   the input channel (in_valid, in_stall, data_byte, last_byte) takes a received frame
//   one byte per request, ip header first, last_byte set on the final byte.
//   the output channel (out_valid, out_stall, verdict and the report fields) gives one
//   request per frame, carrying the verdict and the captured header fields.
//   local_ip is written through cfg_valid/cfg_ready; cfg_ready is always high.
// throughput: one byte per cycle while in_stall is low, across frame boundaries.
// result path: the last byte is taken into the input register, then loads the result register
//   behind the checks once that register is free, raising out_valid.
// stalls: while out_stall holds a pending result, bytes of the next frame keep flowing;
//   only a second last byte waits in the input register, raising in_stall.
// reset: arst_n clears the frame state, local_ip and both valid flags at once;
//   no clearing pass, bytes are taken from the first cycle after reset.
`include "ipv4_receive_header_check_defines.svh"

module ipv4_receive_header_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] local_ip,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict,
	output logic [7:0]  protocol,
	output logic [31:0] source_ip,
	output logic [5:0]  header_bytes,
	output logic [15:0] payload_len,
	output logic [15:0] pad_bytes
);
	import ipv4rhc_pkg::*;

	logic [31:0] local_ip_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        s1_go;
	logic        go;
	logic        res_load;
	logic        out_valid_q;
	frame_t      frame;
	result_t     result;
	result_t     result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			local_ip_q <= local_ip;
		end
	end

	// a last byte moves on only when the result register is free
	assign s1_go    = !(last_s1 && out_valid_q && out_stall);
	assign go       = valid_s1 && s1_go;
	assign res_load = go && last_s1;
	assign in_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ipv4rhc_frame_acc u_frame_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.frame     (frame)
	);

	ipv4rhc_verdict u_verdict (
		.frame    (frame),
		.local_ip (local_ip_q),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = result_q.verdict;
	assign protocol     = result_q.protocol;
	assign source_ip    = result_q.source_ip;
	assign header_bytes = result_q.header_bytes;
	assign payload_len  = result_q.payload_len;
	assign pad_bytes    = result_q.pad_bytes;

	// a result appears only behind a last byte
	`IPV4RHC_ASSERT_NEXT(a_result_from_last, clk, arst_n,
		!res_load && !(out_valid_q && out_stall), !out_valid)
	// delivered frames carry a full header
	`IPV4RHC_ASSERT_IMPLIES(a_deliver_hdr, clk, arst_n,
		out_valid && verdict == VerdictDeliver, header_bytes >= 6'd20)
	// delivered frames carry a supported protocol
	`IPV4RHC_ASSERT_IMPLIES(a_deliver_proto, clk, arst_n,
		out_valid && verdict == VerdictDeliver,
		protocol == ProtoIcmp || protocol == ProtoUdp)

endmodule
